// File: rtl/uta_pkg.sv
// uta_pkg: shared types, constants and the digit-to-ascii mapping
// used by the radix converter modules; depends on nothing
package uta_pkg;

  localparam int IN_W    = 16;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

  typedef struct packed {
    logic load;
    logic next;
  } div_ctl_t;

  typedef struct packed {
    logic               done;
    logic               quo_zero;
    logic [RADIX_W-1:0] digit;
  } div_st_t;

  typedef struct packed {
    logic               push;
    logic               pop_en;
    logic [RADIX_W-1:0] digit;
  } emit_ctl_t;

  typedef struct packed {
    logic empty;
  } emit_st_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d >= DIGIT_TEN) begin
      return CHAR_A + dx - {1'b0, DIGIT_TEN};
    end
    return CHAR_ZERO + dx;
  endfunction

endpackage

// File: rtl/uta_div.sv
// uta_div: bit-serial restoring divider, one quotient bit per cycle
// depends on uta_pkg
module uta_div
  import uta_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]     radix,
  output div_st_t                st
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [RADIX_W:0]       rem_sh;
  logic [RADIX_W:0]       rem_sub;
  logic                   ge;

  assign rem_sh  = {rem_r, q_r[VALUE_WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, radix};
  assign rem_sub = rem_sh - {1'b0, radix};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.load || ctl.next) begin
      if (ctl.load) begin
        q_nxt = value;
      end
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_WIDTH-2:0], ge};
      rem_nxt = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign st.done     = done_r;
  assign st.quo_zero = (q_r == '0);
  assign st.digit    = rem_r;

endmodule

// File: rtl/uta_emit.sv
// uta_emit: digit stack and output register, pops most significant digit first
// depends on uta_pkg
module uta_emit
  import uta_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  emit_ctl_t         ctl,
  output emit_st_t          st,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W = $clog2(VALUE_WIDTH);

  logic [RADIX_W-1:0] stack_r [VALUE_WIDTH];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_m1;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic               pop;

  assign cnt_m1 = cnt_r - 1'b1;
  assign pop    = ctl.pop_en && (cnt_r != '0) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack_r[cnt_r[IDX_W-1:0]] <= ctl.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_r <= digit_to_ascii(stack_r[cnt_m1[IDX_W-1:0]]);
      last_r <= (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.push) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop) begin
        cnt_r <= cnt_m1;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.empty      = (cnt_r == '0);
  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

// File: rtl/unsigned_to_ascii_radix.sv
// unsigned_to_ascii_radix: unsigned value to ascii digit string in a programmable base
// top level; depends on uta_pkg, uta_div and uta_emit
//
// usage:
//   input channel in_valid/in_stall/in_value carries one number per word; the
//   low VALUE_WIDTH bits are converted. result channel out_valid/out_stall
//   carries one ascii character per word, most significant digit first, with
//   out_last set on the final character. zero gives the single character '0'.
//   cfg_we/cfg_wdata writes the base; values are clamped to 2..36, reset is 10.
//   write the base only while no conversion is in flight.
// timing:
//   each digit is one full division by the base in the serial divider (one quotient
//   bit per cycle), then the characters leave at one per cycle while out_stall is low.
//   in_stall is low only while idle; the last character may still sit in the
//   output register when the next word is taken.
// reset and stall:
//   synchronous reset clears the control state and sets the base to 10. a
//   stalled output word holds; the digit stack simply waits behind it.
module unsigned_to_ascii_radix
  import uta_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IN_W-1:0]    in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [VALUE_WIDTH-1:0] value_ext;
  div_ctl_t               div_ctl;
  div_st_t                div_st;
  emit_ctl_t              emit_ctl;
  emit_st_t               emit_st;

  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      value_ext[i] = (i < IN_W) ? in_value[i % IN_W] : 1'b0;
    end
  end

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we) begin
      if (cfg_wdata < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wdata > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    div_ctl         = '0;
    emit_ctl.push   = 1'b0;
    emit_ctl.pop_en = 1'b0;
    emit_ctl.digit  = div_st.digit;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          div_ctl.load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          emit_ctl.push = 1'b1;
          if (div_st.quo_zero) begin
            state_nxt = S_EMIT;
          end else begin
            div_ctl.next = 1'b1;
          end
        end
      end
      S_EMIT: begin
        emit_ctl.pop_en = 1'b1;
        if (emit_st.empty) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radix_r <= RADIX_RESET;
    end else begin
      state_r <= state_nxt;
      radix_r <= radix_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  uta_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .value(value_ext),
    .radix(radix_r),
    .st   (div_st)
  );

  uta_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (emit_ctl),
    .st           (emit_st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

`ifndef SYNTHESIS
  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    radix_r >= RADIX_MIN && radix_r <= RADIX_MAX)
    else $error("base register out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside conversion");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> emit_st.empty)
    else $error("digit stack not drained when idle");

  a_push_then_state: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ctl.push && div_st.quo_zero |=> state_r == S_EMIT && !emit_st.empty)
    else $error("final digit push did not start emission");
`endif

endmodule

// File: dv/unsigned_to_ascii_radix_tb.sv
// unsigned_to_ascii_radix_tb: self-checking bench for the radix converter, predicts
// the ascii digit string of each accepted number and checks every character word
// depends on uta_pkg and unsigned_to_ascii_radix
`timescale 1ns / 100ps

module unsigned_to_ascii_radix_tb
  import uta_pkg::*;
();

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              is_last;
  } ascii_char_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [RADIX_W-1:0] cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [IN_W-1:0]    in_value      = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  ascii_char_t pending_chars[$];
  int          model_radix    = 10;
  int          fail_count     = 0;
  int          send_idle_pct  = 8;
  int          recv_stall_pct = 63;

  unsigned_to_ascii_radix DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("unsigned_to_ascii_radix_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [CHAR_W-1:0] glyph_of(input int d);
    if (d < 10) begin
      return CHAR_W'(48 + d);
    end
    return CHAR_W'(65 + d - 10);
  endfunction

  // push the expected characters of one number, most significant first
  function automatic void predict_chars(input logic [IN_W-1:0] v);
    int          digits[16];
    int          n;
    int          q;
    ascii_char_t c;
    q = v;
    n = 0;
    do begin
      if (n < 16) begin
        digits[n] = q % model_radix;
        n++;
      end
      q = q / model_radix;
    end while (q != 0);
    for (int k = n - 1; k >= 0; k--) begin
      c.chr     = glyph_of(digits[k]);
      c.is_last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    ascii_char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: character %0d last %0b", out_character, out_last);
        fail_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_character !== exp_c.chr) begin
          $error("out_character mismatch: expected %0d, got %0d", exp_c.chr, out_character);
          fail_count++;
        end
        if (out_last !== exp_c.is_last) begin
          $error("out_last mismatch: expected %0b, got %0b", exp_c.is_last, out_last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_value(input logic [IN_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    predict_chars(v);
  endtask

  task automatic drain_chars();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] w);
    int v;
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    v = w;
    if (v < RADIX_MIN) v = RADIX_MIN;
    if (v > RADIX_MAX) v = RADIX_MAX;
    model_radix = v;
  endtask

  function automatic logic [IN_W-1:0] pick_value();
    int p;
    case ($urandom_range(3))
      0: return IN_W'($urandom_range(65535));
      1: return IN_W'($urandom_range(model_radix * model_radix));
      2: begin
        p = 1;
        repeat ($urandom_range(1, 16)) begin
          if (p * model_radix <= 65535) p = p * model_radix;
        end
        return IN_W'($urandom_range(1) ? p : p - 1);
      end
      default: return IN_W'($urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 65535 : 1));
    endcase
  endfunction

  // base after reset is ten
  task automatic test_default_base();
    send_value(16'd0);
    send_value(16'hFFFF);
    send_value(16'd1);
    send_value(16'd9);
    send_value(16'd10);
    send_value(16'd12345);
    drain_chars();
  endtask

  // clamping at both ends, binary, hex and base 36
  task automatic test_base_clamp();
    write_radix(6'd0);
    send_value(16'hFFFF);
    send_value(16'h8000);
    send_value(16'd0);
    drain_chars();
    write_radix(6'd1);
    send_value(16'h5555);
    drain_chars();
    write_radix(6'd63);
    send_value(16'hFFFF);
    send_value(16'd35);
    drain_chars();
    write_radix(6'd37);
    send_value(16'd1295);
    drain_chars();
    write_radix(6'd36);
    send_value(16'd1296);
    drain_chars();
    write_radix(6'd16);
    send_value(16'hABCD);
    send_value(16'hFFFF);
    send_value(16'd0);
    drain_chars();
    write_radix(6'd2);
    send_value(16'hAAAA);
    drain_chars();
  endtask

  task automatic test_random_values(input int idle_pct, input int stall_pct, input int n);
    int sent;
    int burst;
    logic [RADIX_W-1:0] w;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      w = ($urandom_range(5) == 0) ? RADIX_W'($urandom_range(63))
                                   : RADIX_W'($urandom_range(2, 36));
      write_radix(w);
      burst = $urandom_range(15, 35);
      if (burst > n - sent) burst = n - sent;
      repeat (burst) begin
        send_value(pick_value());
        sent++;
      end
      drain_chars();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_base();
    test_base_clamp();
    test_random_values(8, 63, 150);
    test_random_values(63, 8, 150);
    test_random_values(0, 0, 150);
    drain_chars();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("unsigned_to_ascii_radix_tb passed");
    end else begin
      $display("unsigned_to_ascii_radix_tb failed");
    end
    $finish;
  end

endmodule
